// ----- rtl/core/izn_pkg.sv -----
package izn_pkg;

    // Neuron count and field widths
    localparam int NEURONS    = 256;
    localparam int ADDR_W     = $clog2(NEURONS);
    localparam int IDX_W      = 8;
    localparam int CUR_W      = 16;
    localparam int STATE_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int JUMP_W     = 15;

    // Datapath widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int PART_W = 36;
    localparam int DV_W   = 44;
    localparam int LO_W   = 38;
    localparam int DVDT_W = 49;
    localparam int WIDE_W = 50;

    // Long division by the constant 25, one byte of the dividend per pass
    localparam int DIVISOR    = 25;
    localparam int DIV_NUM_W  = 48;
    localparam int DIV_STEP   = 8;
    localparam int DIV_PASSES = DIV_NUM_W / DIV_STEP;
    localparam int DIV_CNT_W  = $clog2(DIV_PASSES + 1);
    localparam int REM_W      = $clog2(DIVISOR);
    localparam int QUO_W      = 42;

    localparam logic signed [STATE_W-1:0] THRESH_Q16 = 32'sh001E_0000;
    localparam logic signed [PART_W-1:0]  C140_Q16   = 36'sh0_008C_0000;
    localparam logic signed [WIDE_W-1:0]  SAT_HI     = 50'sd2147483647;
    localparam logic signed [WIDE_W-1:0]  SAT_LO     = -50'sd2147483648;

    typedef enum logic {
        OP_STEP = 1'b0,
        OP_INIT = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATE    = 3'd0,
        CFG_SENS    = 3'd1,
        CFG_RESET_V = 3'd2,
        CFG_JUMP    = 3'd3,
        CFG_DT      = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_BV,
        ST_DIFF,
        ST_DU,
        ST_UN,
        ST_WAITQ,
        ST_DVL,
        ST_DVH,
        ST_SUMV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op                     op;
        logic [IDX_W-1:0]        idx;
        logic signed [CUR_W-1:0] cur;
    } t_item;

    typedef struct packed {
        logic [15:0]        rate;
        logic [15:0]        sens;
        logic signed [15:0] c;
        logic [JUMP_W-1:0]  jump;
        logic [15:0]        dt;
    } t_cfg;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic                      fired;
        logic signed [STATE_W-1:0] v;
        logic signed [STATE_W-1:0] u;
    } t_result;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
        logic signed [STATE_W-1:0] r;
        if (x > SAT_HI) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < SAT_LO) begin
            r = 32'sh8000_0000;
        end else begin
            r = STATE_W'(x);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/izn_store.sv -----
module izn_store import izn_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [ADDR_W-1:0]         i_rd_addr,
    input  logic                      i_we,
    input  logic [ADDR_W-1:0]         i_wr_addr,
    input  logic signed [STATE_W-1:0] i_wr_v,
    input  logic signed [STATE_W-1:0] i_wr_u,
    output logic signed [STATE_W-1:0] o_rd_v,
    output logic signed [STATE_W-1:0] o_rd_u
);

    logic signed [STATE_W-1:0] r_mem_v [NEURONS];
    logic signed [STATE_W-1:0] r_mem_u [NEURONS];
    logic signed [STATE_W-1:0] r_rd_v;
    logic signed [STATE_W-1:0] r_rd_u;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem_v[i_wr_addr] <= i_wr_v;
            r_mem_u[i_wr_addr] <= i_wr_u;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_v <= r_mem_v[i_rd_addr];
            r_rd_u <= r_mem_u[i_rd_addr];
        end
    end

    assign o_rd_v = r_rd_v;
    assign o_rd_u = r_rd_u;

endmodule

// ----- rtl/core/izn_div25.sv -----
module izn_div25 import izn_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    output logic                 o_busy,
    output logic [QUO_W-1:0]     o_quo
);

    logic [DIV_NUM_W-1:0] r_num;
    logic [REM_W-1:0]     r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;

    logic [REM_W-1:0]     n_rem;
    logic [DIV_STEP-1:0]  n_qbits;
    logic [REM_W:0]       w_trial;

    // Restoring division, one dividend bit per step, one byte per pass
    always_comb begin
        n_rem   = r_rem;
        n_qbits = '0;
        w_trial = '0;
        for (int k = 0; k < DIV_STEP; k++) begin
            w_trial = {n_rem, r_num[DIV_NUM_W-1-k]};
            if (w_trial >= (REM_W+1)'(DIVISOR)) begin
                n_rem                 = REM_W'(w_trial - (REM_W+1)'(DIVISOR));
                n_qbits[DIV_STEP-1-k] = 1'b1;
            end else begin
                n_rem = w_trial[REM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_PASSES);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= r_num << DIV_STEP;
            r_rem <= n_rem;
            r_quo <= {r_quo[QUO_W-DIV_STEP-1:0], n_qbits};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/core/izn_update.sv -----
module izn_update import izn_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    input  logic    i_out_free,
    output logic    o_busy,
    output logic    o_commit,
    output t_result o_result
);

    t_state r_state;
    t_state n_state;

    t_item                     r_item;
    logic signed [STATE_W-1:0] r_v;
    logic signed [STATE_W-1:0] r_u;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PART_W-1:0]  r_part;
    logic signed [STATE_W-1:0] r_un;
    logic signed [DV_W-1:0]    r_dv;
    logic [LO_W-1:0]           r_lo;
    logic signed [DVDT_W-1:0]  r_dvdt;

    logic signed [MUL_W-1:0]   w_ma;
    logic signed [MUL_W-1:0]   w_mb;
    logic                      w_mul_en;
    logic                      w_div_start;
    logic                      w_div_busy;
    logic [QUO_W-1:0]          w_quo;
    logic                      w_commit;

    logic signed [STATE_W-1:0] w_rd_v;
    logic signed [STATE_W-1:0] w_rd_u;
    logic [ADDR_W-1:0]         w_rd_addr;
    logic [ADDR_W-1:0]         w_wr_addr;

    logic signed [PART_W-1:0]  w_part;
    logic signed [32:0]        w_bv;
    logic signed [MUL_W-1:0]   w_diff;
    logic signed [MUL_W-1:0]   w_du;
    logic signed [STATE_W-1:0] w_un_step;
    logic signed [STATE_W-1:0] w_vn;
    logic signed [STATE_W-1:0] w_uj;
    logic signed [STATE_W-1:0] w_cv;
    logic signed [STATE_W-1:0] w_bc;
    logic                      w_fire;
    t_result                   w_res;

    // Index beyond the array wraps onto the stored entries
    assign w_rd_addr = ADDR_W'(32'(i_item.idx) % NEURONS);
    assign w_wr_addr = ADDR_W'(32'(r_item.idx) % NEURONS);

    // Reads happen only on acceptance and the write only on commit, after which
    // the block is idle again, so a read never meets a pending write.
    izn_store u_store (
        .i_clk     (i_clk),
        .i_rd_en   (i_start),
        .i_rd_addr (w_rd_addr),
        .i_we      (w_commit),
        .i_wr_addr (w_wr_addr),
        .i_wr_v    (w_res.v),
        .i_wr_u    (w_res.u),
        .o_rd_v    (w_rd_v),
        .o_rd_u    (w_rd_u)
    );

    izn_div25 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_prod[63:16]),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    // Arithmetic taps on the product register and held operands
    assign w_part = 36'(r_v) + 36'($signed({r_v, 2'b00})) + C140_Q16 - 36'(r_u)
                  + 36'($signed({r_item.cur, 8'b0}));
    assign w_bv   = $signed(r_prod[48:16]);
    assign w_diff = MUL_W'(w_bv) - MUL_W'(r_u);
    assign w_du   = $signed(r_prod[49:16]);
    assign w_un_step = sat32(WIDE_W'($signed(r_prod[49:12])) + WIDE_W'(r_u));

    assign w_vn   = sat32(WIDE_W'(r_v) + WIDE_W'(r_dvdt));
    assign w_uj   = sat32(WIDE_W'(r_un) + WIDE_W'($signed({1'b0, i_cfg.jump, 8'b0})));
    assign w_cv   = STATE_W'($signed({i_cfg.c, 8'b0}));
    assign w_bc   = STATE_W'($signed(r_prod[31:8]));
    assign w_fire = (w_vn >= THRESH_Q16);

    always_comb begin
        w_res.idx = r_item.idx;
        if (r_item.op == OP_INIT) begin
            w_res.fired = 1'b0;
            w_res.v     = w_cv;
            w_res.u     = w_bc;
        end else if (w_fire) begin
            w_res.fired = 1'b1;
            w_res.v     = w_cv;
            w_res.u     = w_uj;
        end else begin
            w_res.fired = 1'b0;
            w_res.v     = w_vn;
            w_res.u     = r_un;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: one shared multiplier, at most one product per state
    always_comb begin
        n_state     = r_state;
        w_ma        = '0;
        w_mb        = '0;
        w_mul_en    = 1'b0;
        w_div_start = 1'b0;
        w_commit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_mul_en = 1'b1;
                if (r_item.op == OP_INIT) begin
                    w_ma    = MUL_W'($signed(i_cfg.c));
                    w_mb    = MUL_W'(i_cfg.sens);
                    n_state = ST_DONE;
                end else begin
                    w_ma    = MUL_W'(w_rd_v);
                    w_mb    = MUL_W'(w_rd_v);
                    n_state = ST_BV;
                end
            end
            ST_BV: begin
                w_div_start = 1'b1;
                w_mul_en    = 1'b1;
                w_ma        = MUL_W'(i_cfg.sens);
                w_mb        = MUL_W'(r_v);
                n_state     = ST_DIFF;
            end
            ST_DIFF: begin
                w_mul_en = 1'b1;
                w_ma     = MUL_W'(i_cfg.rate);
                w_mb     = w_diff;
                n_state  = ST_DU;
            end
            ST_DU: begin
                w_mul_en = 1'b1;
                w_ma     = MUL_W'(i_cfg.dt);
                w_mb     = w_du;
                n_state  = ST_UN;
            end
            ST_UN: begin
                n_state = ST_WAITQ;
            end
            ST_WAITQ: begin
                if (!w_div_busy) begin
                    n_state = ST_DVL;
                end
            end
            ST_DVL: begin
                w_mul_en = 1'b1;
                w_ma     = MUL_W'(i_cfg.dt);
                w_mb     = MUL_W'(r_dv[21:0]);
                n_state  = ST_DVH;
            end
            ST_DVH: begin
                w_mul_en = 1'b1;
                w_ma     = MUL_W'(i_cfg.dt);
                w_mb     = MUL_W'($signed(r_dv[DV_W-1:22]));
                n_state  = ST_SUMV;
            end
            ST_SUMV: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    w_commit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_start) begin
            r_item <= i_item;
        end
        case (r_state)
            ST_READ: begin
                r_v <= w_rd_v;
                r_u <= w_rd_u;
            end
            ST_BV: begin
                r_part <= w_part;
            end
            ST_UN: begin
                r_un <= w_un_step;
            end
            ST_WAITQ: begin
                r_dv <= $signed(DV_W'(w_quo)) + DV_W'(r_part);
            end
            ST_DVH: begin
                r_lo <= r_prod[LO_W-1:0];
            end
            ST_SUMV: begin
                // dt*dv/2^12 = hi*2^10 + floor(lo/2^12), lo non-negative
                r_dvdt <= $signed({r_prod[38:0], 10'b0})
                        + $signed({23'b0, r_lo[LO_W-1:12]});
            end
            default: begin
            end
        endcase
    end

    assign o_busy   = (r_state != ST_IDLE);
    assign o_commit = w_commit;
    assign o_result = w_res;

endmodule

// ----- rtl/core/izhikevich_neuron_step.sv -----
// Izhikevich neuron array: one forward-Euler step of one neuron per word.
//
// Input channel (i_valid / o_stall): a word carries op, neuron index and input
// current. op step advances the addressed neuron; op init loads v = c and
// u = b*c. A word is taken at a rising edge with i_valid high and o_stall low.
// Output channel (o_valid / i_stall): one result word per input word, in order,
// giving the index, the fired flag and the new v and u in Q16.16.
// Timing: a step word passes through READ, BV, DIFF, DU, UN, WAITQ, DVL, DVH,
// SUMV and DONE, an init word through READ and DONE; no new word is taken
// before the last commits. The step sequence is set by the single shared 34x34
// multiplier, used six times in sequence, and by the divide-by-25 of v^2,
// which retires one byte per cycle. State lives in two 256-entry memories with
// a registered read port, read on acceptance and written on commit.
// Stall: a result waits in the output register while i_stall is high; the
// next word may still be taken and worked on, and holds before commit until
// the register frees.
// Reset (synchronous, active low) clears the sequencer and the output valid and
// loads the parameter registers with their defaults; the neuron memories are
// not cleared, so initialise every neuron before stepping it.
module izhikevich_neuron_step import izn_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [IDX_W-1:0]             i_neuron_index,
    input  logic signed [CUR_W-1:0]      i_input_current,
    // output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [IDX_W-1:0]             o_out_neuron,
    output logic                         o_fired,
    output logic signed [STATE_W-1:0]    o_potential_out,
    output logic signed [STATE_W-1:0]    o_recovery_out,
    // parameter write port
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_cfg    r_cfg;
    t_item   w_item;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_busy;
    logic    w_commit;
    logic    w_accept;
    logic    w_out_free;

    // Parameter registers; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate <= 16'd1311;
            r_cfg.sens <= 16'd13107;
            r_cfg.c    <= -16'sd16640;
            r_cfg.jump <= 15'd2048;
            r_cfg.dt   <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RATE:    r_cfg.rate <= i_cfg_data;
                CFG_SENS:    r_cfg.sens <= i_cfg_data;
                CFG_RESET_V: r_cfg.c    <= $signed(i_cfg_data);
                CFG_JUMP:    r_cfg.jump <= i_cfg_data[JUMP_W-1:0];
                CFG_DT:      r_cfg.dt   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Take a word whenever the sequencer is idle
    assign o_stall  = w_busy;
    assign w_accept = i_valid && !w_busy;

    assign w_item.op  = t_op'(i_op);
    assign w_item.idx = i_neuron_index;
    assign w_item.cur = i_input_current;

    // Output register frees when empty or when its word is taken this edge
    assign w_out_free = !r_out_valid || !i_stall;

    izn_update u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_item     (w_item),
        .i_cfg      (r_cfg),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_commit   (w_commit),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload while stalled; load only on commit
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_out_neuron    = r_out.idx;
    assign o_fired         = r_out.fired;
    assign o_potential_out = r_out.v;
    assign o_recovery_out  = r_out.u;

endmodule

// ----- rtl/core/izn_checker.sv -----
module izn_checker import izn_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [IDX_W-1:0]          o_out_neuron,
    input logic                      o_fired,
    input logic signed [STATE_W-1:0] o_potential_out,
    input logic signed [STATE_W-1:0] o_recovery_out
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A taken word occupies the block on the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not held off after acceptance");

    // A fresh result only follows work in progress
    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no word in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_neuron) && $stable(o_fired)
            && $stable(o_potential_out) && $stable(o_recovery_out)))
        else $error("stalled result changed");

endmodule

bind izhikevich_neuron_step izn_checker u_izn_checker (.*);
